>>> rtl/core/tfrs_pkg.sv
// shared types, constants and helpers of the transmit frame ring retry scheduler
// used by every module of the block; no dependencies
package tfrs_pkg;

  localparam int CHANNELS        = 2;
  localparam int RING_DEPTH      = 8;
  localparam int MAX_FRAME_BYTES = 255;
  localparam int MAX_RESULTS     = 8;
  localparam int CMDQ_DEPTH      = 2;

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W  = $clog2(RING_DEPTH);
  localparam int FILL_W  = $clog2(RING_DEPTH + 1);
  localparam int LEN_AW  = $clog2(CHANNELS * RING_DEPTH);
  localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int CMDQ_AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CW = $clog2(CMDQ_DEPTH + 1);
  localparam int TICK_W  = 32;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 16;

  localparam logic [1:0] FUNC_ENQ  = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_DONE = 2'd2;
  localparam logic [1:0] FUNC_ERR  = 2'd3;

  localparam logic [CFG_AW-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_GAP     = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_LIMIT   = 2'd2;

  localparam logic [15:0] TIMEOUT_RST = 16'd50;
  localparam logic [15:0] GAP_RST     = 16'd10;
  localparam logic [3:0]  LIMIT_RST   = 4'd3;

  typedef enum logic [3:0] {
    K_QUEUED  = 4'd0,
    K_FULL    = 4'd1,
    K_INVALID = 4'd2,
    K_START   = 4'd3,
    K_ABORT   = 4'd4,
    K_SENT    = 4'd5,
    K_ERROR   = 4'd6,
    K_IGNORED = 4'd7,
    K_DROPPED = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ENQ     = 3'd1,
    OP_DONE    = 3'd2,
    OP_ERR     = 3'd3,
    OP_BAD_CH  = 3'd4,
    OP_BAD_LEN = 3'd5
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] channel;
    logic       urgent;
    logic       use_seq;
    logic [7:0] seq;
    logic [7:0] length;
  } cmd_t;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] channel;
    logic [2:0] slot;
    logic [7:0] length;
    logic [7:0] seq;
    logic [3:0] retry;
    logic       last;
  } res_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

  function automatic logic [LEN_AW-1:0] len_addr(input logic [CH_W-1:0] ch,
                                                 input logic [SLOT_W-1:0] s);
    return LEN_AW'(int'(ch) * RING_DEPTH + int'(s));
  endfunction

endpackage

>>> rtl/core/tfrs_front.sv
// front end: takes input events and classifies them into queue commands
// depends on tfrs_pkg
module tfrs_front import tfrs_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [2:0] channel_i,
  input  logic       urgent_i,
  input  logic       use_given_seq_i,
  input  logic [7:0] given_seq_i,
  input  logic [7:0] frame_length_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cmd_t       q_cmd_o
);

  op_e op;

  always_comb begin
    op = OP_TICK;
    if (func_i == FUNC_TICK) begin
      op = OP_TICK;
    end else if (channel_i >= 3'(CHANNELS)) begin
      op = OP_BAD_CH;
    end else begin
      case (func_i)
        FUNC_ENQ: begin
          if (frame_length_i inside {[1:MAX_FRAME_BYTES]}) begin
            op = OP_ENQ;
          end else begin
            op = OP_BAD_LEN;
          end
        end
        FUNC_DONE: op = OP_DONE;
        FUNC_ERR:  op = OP_ERR;
        default:   op = OP_TICK;
      endcase
    end
  end

  assign in_ready_o       = !q_full_i;
  assign q_push_o         = in_valid_i && !q_full_i;
  assign q_cmd_o.op       = op;
  assign q_cmd_o.channel  = channel_i;
  assign q_cmd_o.urgent   = urgent_i;
  assign q_cmd_o.use_seq  = use_given_seq_i;
  assign q_cmd_o.seq      = given_seq_i;
  assign q_cmd_o.length   = frame_length_i;

endmodule

>>> rtl/core/tfrs_cmd_fifo.sv
// short command queue between the front end and the scheduler back end
// depends on tfrs_pkg
module tfrs_cmd_fifo import tfrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t               mem_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr_q, wptr_d;
  logic [CMDQ_AW-1:0] rptr_q, rptr_d;
  logic [CMDQ_CW-1:0] count_q, count_d;

  function automatic logic [CMDQ_AW-1:0] ptr_inc(input logic [CMDQ_AW-1:0] p);
    logic [CMDQ_AW-1:0] r;
    if (p == CMDQ_AW'(CMDQ_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + CMDQ_AW'(1);
    end
    return r;
  endfunction

  assign full_o  = (count_q == CMDQ_CW'(CMDQ_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = push_i ? ptr_inc(wptr_q) : wptr_q;
    rptr_d  = pop_i ? ptr_inc(rptr_q) : rptr_q;
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CMDQ_CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CMDQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> rtl/core/tfrs_back.sv
// back end: per-channel rings, send state, timeout and retry sequencer, result output
// depends on tfrs_pkg; fed by tfrs_cmd_fifo
module tfrs_back import tfrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              q_empty_i,
  input  cmd_t              q_head_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output res_t              out_res_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_TICK  = 3'd3;
  localparam logic [2:0] S_ABORT = 3'd4;
  localparam logic [2:0] S_RETRY = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  logic [15:0] timeout_q, gap_q;
  logic [3:0]  limit_q;

  logic [2:0]        state_q, state_d;
  logic [CH_W-1:0]   ch_q, ch_d;
  cmd_t              cmd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [TICK_W-1:0] now_q;

  logic [7:0]        seq_q     [CHANNELS];
  logic [SLOT_W-1:0] head_q    [CHANNELS];
  logic [SLOT_W-1:0] tail_q    [CHANNELS];
  logic [FILL_W-1:0] fill_q    [CHANNELS];
  logic              sending_q [CHANNELS];
  logic              rw_q      [CHANNELS];
  logic [3:0]        retry_q   [CHANNELS];
  logic [TICK_W-1:0] sst_q     [CHANNELS];
  logic [7:0]        len_mem_q [CHANNELS * RING_DEPTH];

  res_t hold_q, out_q, move_res;
  logic hold_v_q, out_v_q;

  logic [7:0]        seq_c, seq_n;
  logic [SLOT_W-1:0] head_c, head_n, tail_c, tail_n;
  logic [FILL_W-1:0] fill_c, fill_n;
  logic              sending_c, sending_n, rw_c, rw_n;
  logic [3:0]        retry_c, retry_n;
  logic [TICK_W-1:0] sst_c, sst_n, age;
  logic [7:0]        head_len;

  logic        emit_req, emit_ok, emit_fire, go, commit, last_ch;
  logic        len_we, now_inc, pop, flush_fire;
  logic [FILL_W-1:0] enq_limit;
  res_t        new_res;

  assign seq_c     = seq_q[ch_q];
  assign head_c    = head_q[ch_q];
  assign tail_c    = tail_q[ch_q];
  assign fill_c    = fill_q[ch_q];
  assign sending_c = sending_q[ch_q];
  assign rw_c      = rw_q[ch_q];
  assign retry_c   = retry_q[ch_q];
  assign sst_c     = sst_q[ch_q];
  assign head_len  = len_mem_q[len_addr(ch_q, head_c)];
  assign age       = now_q - sst_c;
  assign last_ch   = (ch_q == CH_W'(CHANNELS - 1));
  assign enq_limit = cmd_q.urgent ? FILL_W'(RING_DEPTH) : FILL_W'(RING_DEPTH - 1);

  logic out_free;
  assign out_free   = !out_v_q || out_ready_i;
  assign emit_ok    = (cnt_q >= CNT_W'(MAX_RESULTS)) || !hold_v_q || out_free;
  assign go         = !emit_req || emit_ok;
  assign emit_fire  = emit_req && go && (cnt_q < CNT_W'(MAX_RESULTS));
  assign flush_fire = (state_q == S_FLUSH) && hold_v_q && out_free;

  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    emit_req  = 1'b0;
    new_res   = '0;
    commit    = 1'b0;
    len_we    = 1'b0;
    now_inc   = 1'b0;
    pop       = 1'b0;
    seq_n     = seq_c;
    head_n    = head_c;
    tail_n    = tail_c;
    fill_n    = fill_c;
    sending_n = sending_c;
    rw_n      = rw_c;
    retry_n   = retry_c;
    sst_n     = sst_c;
    new_res.channel = 3'(ch_q);
    new_res.retry   = retry_c;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          pop = 1'b1;
          if (q_head_i.op == OP_TICK) begin
            ch_d    = '0;
            state_d = S_TICK;
          end else begin
            ch_d    = q_head_i.channel[CH_W-1:0];
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        emit_req = 1'b1;
        commit   = 1'b1;
        state_d  = S_FLUSH;
        case (cmd_q.op)
          OP_BAD_CH: begin
            new_res.kind    = K_INVALID;
            new_res.channel = cmd_q.channel;
            new_res.retry   = '0;
          end
          OP_BAD_LEN: begin
            new_res.kind    = K_INVALID;
            new_res.channel = cmd_q.channel;
          end
          OP_ENQ: begin
            if (fill_c >= enq_limit) begin
              new_res.kind = K_FULL;
            end else begin
              new_res.kind   = K_QUEUED;
              new_res.slot   = 3'(tail_c);
              new_res.length = cmd_q.length;
              new_res.seq    = cmd_q.use_seq ? cmd_q.seq : seq_c;
              if (!cmd_q.use_seq) begin
                seq_n = seq_c + 8'd1;
              end
              len_we = 1'b1;
              tail_n = slot_inc(tail_c);
              fill_n = fill_c + FILL_W'(1);
              if (!sending_c) begin
                state_d = S_START;
              end
            end
          end
          OP_DONE: begin
            if (!sending_c || fill_c == '0) begin
              new_res.kind = K_IGNORED;
            end else begin
              new_res.kind   = K_SENT;
              new_res.slot   = 3'(head_c);
              new_res.length = head_len;
              new_res.retry  = '0;
              head_n  = slot_inc(head_c);
              fill_n  = fill_c - FILL_W'(1);
              retry_n = '0;
              rw_n    = 1'b0;
              if (fill_c > FILL_W'(1)) begin
                state_d = S_START;
              end else begin
                sending_n = 1'b0;
              end
            end
          end
          OP_ERR: begin
            if (!sending_c || fill_c == '0) begin
              new_res.kind = K_IGNORED;
            end else begin
              new_res.kind = K_ERROR;
              new_res.slot = 3'(head_c);
              sending_n    = 1'b0;
              rw_n         = 1'b1;
              sst_n        = now_q;
            end
          end
          default: begin
            new_res.kind = K_IGNORED;
          end
        endcase
      end
      S_START: begin
        emit_req       = 1'b1;
        commit         = 1'b1;
        new_res.kind   = K_START;
        new_res.slot   = 3'(head_c);
        new_res.length = head_len;
        sending_n      = 1'b1;
        rw_n           = 1'b0;
        sst_n          = now_q;
        if (cmd_q.op != OP_TICK || last_ch) begin
          state_d = S_FLUSH;
        end else begin
          ch_d    = ch_q + CH_W'(1);
          state_d = S_RETRY;
        end
      end
      S_TICK: begin
        now_inc = 1'b1;
        state_d = S_ABORT;
      end
      S_ABORT: begin
        commit = 1'b1;
        if (sending_c && fill_c != '0 && age > TICK_W'(timeout_q)) begin
          emit_req     = 1'b1;
          new_res.kind = K_ABORT;
          new_res.slot = 3'(head_c);
          sending_n    = 1'b0;
          rw_n         = 1'b1;
          sst_n        = now_q;
        end
        if (last_ch) begin
          ch_d    = '0;
          state_d = S_RETRY;
        end else begin
          ch_d = ch_q + CH_W'(1);
        end
      end
      S_RETRY: begin
        commit = 1'b1;
        if (last_ch) begin
          state_d = S_FLUSH;
        end else begin
          ch_d = ch_q + CH_W'(1);
        end
        if (sending_c || fill_c == '0 || (rw_c && age < TICK_W'(gap_q))) begin
          // channel has nothing to do on this tick
        end else begin
          ch_d    = ch_q;
          state_d = S_START;
          if (rw_c) begin
            rw_n = 1'b0;
            if (retry_c >= limit_q) begin
              emit_req       = 1'b1;
              new_res.kind   = K_DROPPED;
              new_res.slot   = 3'(head_c);
              new_res.length = head_len;
              head_n         = slot_inc(head_c);
              fill_n         = fill_c - FILL_W'(1);
              retry_n        = '0;
              if (fill_c == FILL_W'(1)) begin
                if (last_ch) begin
                  state_d = S_FLUSH;
                end else begin
                  ch_d    = ch_q + CH_W'(1);
                  state_d = S_RETRY;
                end
              end
            end else begin
              retry_n = retry_c + 4'd1;
            end
          end
        end
      end
      S_FLUSH: begin
        if (!hold_v_q || out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    move_res      = hold_q;
    move_res.last = flush_fire;
  end

  assign q_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      gap_q     <= GAP_RST;
      limit_q   <= LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_TIMEOUT: timeout_q <= cfg_wdata_i;
        CFG_GAP:     gap_q     <= cfg_wdata_i;
        CFG_LIMIT:   limit_q   <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ch_q     <= '0;
      cnt_q    <= '0;
      now_q    <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        seq_q[i]     <= '0;
        head_q[i]    <= '0;
        tail_q[i]    <= '0;
        fill_q[i]    <= '0;
        sending_q[i] <= 1'b0;
        rw_q[i]      <= 1'b0;
        retry_q[i]   <= '0;
        sst_q[i]     <= '0;
      end
    end else begin
      if (go) begin
        state_q <= state_d;
        ch_q    <= ch_d;
      end
      if (pop) begin
        cnt_q <= '0;
      end else if (emit_fire) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (now_inc) begin
        now_q <= now_q + TICK_W'(1);
      end
      if (commit && go) begin
        seq_q[ch_q]     <= seq_n;
        head_q[ch_q]    <= head_n;
        tail_q[ch_q]    <= tail_n;
        fill_q[ch_q]    <= fill_n;
        sending_q[ch_q] <= sending_n;
        rw_q[ch_q]      <= rw_n;
        retry_q[ch_q]   <= retry_n;
        sst_q[ch_q]     <= sst_n;
      end
      if (emit_fire) begin
        hold_v_q <= 1'b1;
      end else if (flush_fire) begin
        hold_v_q <= 1'b0;
      end
      if ((emit_fire && hold_v_q) || flush_fire) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q <= q_head_i;
    end
    if (len_we && go) begin
      len_mem_q[len_addr(ch_q, tail_c)] <= cmd_q.length;
    end
    if (emit_fire) begin
      hold_q <= new_res;
    end
    if ((emit_fire && hold_v_q) || flush_fire) begin
      out_q <= move_res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

`ifndef SYNTHESIS
  a_send_has_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sending_q[0] |-> (fill_q[0] != '0))
    else $error("channel sending with an empty ring");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[0] <= FILL_W'(RING_DEPTH))
    else $error("ring fill above depth");
  a_send_wait_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sending_q[0] && rw_q[0]))
    else $error("channel both sending and waiting to retry");
  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !hold_v_q)
    else $error("held result left over between events");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("result count overflow");
`endif

endmodule

>>> rtl/core/tx_frame_ring_retry_scheduler.sv
// top level of the transmit frame ring retry scheduler
// depends on tfrs_pkg, tfrs_front, tfrs_cmd_fifo and tfrs_back

// Each channel keeps a ring of frame lengths and a send state; events are enqueue, tick,
// send done and send error, and each event yields zero or more result transfers, the
// final one marked by last_o. The front end classifies an event in the cycle it is
// accepted and puts it in a two-entry command queue, so inputs keep flowing while the
// back end works, until the queue is full. The back end sequencer handles one event at a
// time: it takes the event from the queue; an enqueue, send done or send error then
// executes, may start a send, and closes; a tick advances time, checks each channel for
// a timeout, checks each channel for a retry, starting or dropping any due frame, and
// closes. A result is formed in the cycle of its step, which waits only while the held
// result cannot move on to the output register.
// Configuration writes take effect at once and are meant for idle periods only.
module tx_frame_ring_retry_scheduler import tfrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic [2:0]        channel_i,
  input  logic              urgent_i,
  input  logic              use_given_seq_i,
  input  logic [7:0]        given_seq_i,
  input  logic [7:0]        frame_length_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3:0]        kind_o,
  output logic [2:0]        out_channel_o,
  output logic [2:0]        slot_o,
  output logic [7:0]        out_length_o,
  output logic [7:0]        out_seq_o,
  output logic [3:0]        retry_number_o,
  output logic              last_o
);

  logic q_full, q_push, q_pop, q_empty;
  cmd_t push_cmd, head_cmd;
  res_t res;

  tfrs_front u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .channel_i       (channel_i),
    .urgent_i        (urgent_i),
    .use_given_seq_i (use_given_seq_i),
    .given_seq_i     (given_seq_i),
    .frame_length_i  (frame_length_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (push_cmd)
  );

  tfrs_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (head_cmd)
  );

  tfrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_empty_i   (q_empty),
    .q_head_i    (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (res)
  );

  assign kind_o         = res.kind;
  assign out_channel_o  = res.channel;
  assign slot_o         = res.slot;
  assign out_length_o   = res.length;
  assign out_seq_o      = res.seq;
  assign retry_number_o = res.retry;
  assign last_o         = res.last;

endmodule
